>>> hw/rtl/flvd_pkg.sv
`timescale 1ns / 1ps

package flvd_pkg;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_SEEK     = 4'd1,
        PH_PREV     = 4'd2,
        PH_TAGHDR   = 4'd3,
        PH_VINFO    = 4'd4,
        PH_PKTTYPE  = 4'd5,
        PH_COMPTIME = 4'd6,
        PH_NALULEN  = 4'd7,
        PH_NALUDATA = 4'd8,
        PH_SKIPTAG  = 4'd9
    } phase_t;

    localparam logic       CFG_AVC_CODEC_ID     = 1'b0;
    localparam logic       CFG_EMIT_TAG_RECORDS = 1'b1;

    localparam logic       KIND_NALU_BYTE  = 1'b0;
    localparam logic       KIND_TAG_RECORD = 1'b1;

    localparam logic [4:0] TAG_VIDEO       = 5'd9;
    localparam logic [7:0] PKT_NALU        = 8'd1;
    localparam logic [3:0] HDR_OFFSET_POS  = 4'd5;
    localparam logic [3:0] HDR_LEN         = 4'd9;
    localparam logic [3:0] PREV_LEN        = 4'd4;
    localparam logic [3:0] TAGHDR_LEN      = 4'd11;
    localparam logic [3:0] SIZE_LAST_POS   = 4'd3;
    localparam logic [3:0] TIME_LAST_POS   = 4'd6;
    localparam logic [3:0] TIME_EXT_POS    = 4'd7;
    localparam logic [3:0] COMPTIME_LEN    = 4'd3;
    localparam logic [3:0] NALULEN_LEN     = 4'd4;
    localparam logic [31:0] MIN_BODY_OFFSET = 32'd9;

    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  payload_byte;
        logic        last_of_nalu;
        logic [4:0]  tag_kind;
        logic [23:0] tag_size;
        logic [31:0] tag_time;
        logic        overrun;
    } result_t;

endpackage

>>> hw/rtl/flv_avc_nalu_demux.sv
`timescale 1ns / 1ps

// FLV demultiplexer: one file byte per input beat, NALU bytes and tag records out.
// Input channel: in_valid/in_ready with data_byte and start_of_file; start_of_file
//   restarts the parser on that byte.
// Output channel: out_valid/out_ready; record_kind 0 carries one NALU byte with
//   last_of_nalu and overrun, record_kind 1 carries a tag header record.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 avc_codec_id, index 1
//   emit_tag_records. Write only while idle.
// Throughput: one byte per cycle while the queue has space, set by the single-byte parse step in the front.
// Result path: a result is written into a 4-entry queue at the accepting edge, then moves
//   into the output register, which drives out_valid.
// Reset: parser returns to the file header phase, queue and output empty,
//   avc_codec_id = 7, emit_tag_records = 1.
// Receiver stall: the output register holds its beat; the queue absorbs up to
//   four results, after which in_ready drops until space frees.
module flv_avc_nalu_demux import flvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        record_kind,
    output logic [7:0]  payload_byte,
    output logic        last_of_nalu,
    output logic [4:0]  tag_kind,
    output logic [23:0] tag_size,
    output logic [31:0] tag_time,
    output logic        overrun,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    logic    push, pop, q_full, q_empty;
    result_t push_data, q_data, out_data;

    flvd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    flvd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    flvd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign record_kind  = out_data.record_kind;
    assign payload_byte = out_data.payload_byte;
    assign last_of_nalu = out_data.last_of_nalu;
    assign tag_kind     = out_data.tag_kind;
    assign tag_size     = out_data.tag_size;
    assign tag_time     = out_data.tag_time;
    assign overrun      = out_data.overrun;

endmodule

>>> hw/rtl/flvd_front.sv
`timescale 1ns / 1ps

module flvd_front import flvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        q_full,
    output logic        push,
    output result_t     push_data
);

    phase_t      phase_reg, phase_next, ph_cur;
    logic [3:0]  count_reg, count_next, cnt_cur;
    logic [31:0] pos_reg, pos_next, pos_cur;
    logic [31:0] offset_reg, offset_next, off_cur;
    logic [4:0]  kind_reg, kind_next, kind_cur;
    logic [23:0] left_reg, left_next, left_cur;
    logic [31:0] time_reg, time_next, time_cur;
    logic [31:0] nalu_reg, nalu_next, nalu_cur;
    logic        cut_reg, cut_next, cut_cur;
    logic [3:0]  codec_reg;
    logic        emit_reg;

    logic        accept;
    logic [3:0]  cnt_inc;
    logic [23:0] left_dec;
    logic        tag_end;
    logic [31:0] nalu_shift;
    logic [31:0] nalu_dec;
    logic        emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ph_cur   = start_of_file ? PH_HEADER : phase_reg;
        cnt_cur  = start_of_file ? 4'd0  : count_reg;
        pos_cur  = start_of_file ? 32'd0 : pos_reg;
        off_cur  = start_of_file ? 32'd0 : offset_reg;
        kind_cur = start_of_file ? 5'd0  : kind_reg;
        left_cur = start_of_file ? 24'd0 : left_reg;
        time_cur = start_of_file ? 32'd0 : time_reg;
        nalu_cur = start_of_file ? 32'd0 : nalu_reg;
        cut_cur  = start_of_file ? 1'b0  : cut_reg;

        cnt_inc    = cnt_cur + 4'd1;
        left_dec   = left_cur - 24'd1;
        tag_end    = (left_dec == 24'd0);
        nalu_shift = {nalu_cur[23:0], data_byte};
        nalu_dec   = nalu_cur - 32'd1;

        phase_next  = ph_cur;
        count_next  = cnt_cur;
        pos_next    = pos_cur + 32'd1;
        offset_next = off_cur;
        kind_next   = kind_cur;
        left_next   = left_cur;
        time_next   = time_cur;
        nalu_next   = nalu_cur;
        cut_next    = cut_cur;

        emit      = 1'b0;
        push_data = '0;

        unique case (ph_cur)
            PH_HEADER:
            begin
                if (cnt_cur >= HDR_OFFSET_POS)
                    offset_next = {off_cur[23:0], data_byte};
                count_next = cnt_inc;
                if (cnt_inc >= HDR_LEN)
                begin
                    count_next = 4'd0;
                    phase_next = (offset_next <= MIN_BODY_OFFSET) ? PH_PREV : PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (pos_next >= off_cur)
                begin
                    phase_next = PH_PREV;
                    count_next = 4'd0;
                end
            end
            PH_PREV:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= PREV_LEN)
                begin
                    phase_next = PH_TAGHDR;
                    count_next = 4'd0;
                end
            end
            PH_TAGHDR:
            begin
                if (cnt_cur == 4'd0)
                begin
                    kind_next = data_byte[4:0];
                    left_next = 24'd0;
                    time_next = 32'd0;
                end
                else if (cnt_cur <= SIZE_LAST_POS)
                    left_next = {left_cur[15:0], data_byte};
                else if (cnt_cur <= TIME_LAST_POS)
                    time_next = {8'd0, time_cur[15:0], data_byte};
                else if (cnt_cur == TIME_EXT_POS)
                    time_next = {data_byte, time_cur[23:0]};
                count_next = cnt_inc;
                if (cnt_inc >= TAGHDR_LEN)
                begin
                    count_next = 4'd0;
                    if (emit_reg)
                    begin
                        emit                   = 1'b1;
                        push_data.record_kind  = KIND_TAG_RECORD;
                        push_data.tag_kind     = kind_cur;
                        push_data.tag_size     = left_cur;
                        push_data.tag_time     = time_cur;
                    end
                    if (left_cur == 24'd0)
                        phase_next = PH_PREV;
                    else if (kind_cur == TAG_VIDEO)
                        phase_next = PH_VINFO;
                    else
                        phase_next = PH_SKIPTAG;
                end
            end
            PH_VINFO:
            begin
                left_next  = left_dec;
                count_next = 4'd0;
                if (tag_end)
                    phase_next = PH_PREV;
                else
                    phase_next = (data_byte[3:0] == codec_reg) ? PH_PKTTYPE : PH_SKIPTAG;
            end
            PH_PKTTYPE:
            begin
                left_next  = left_dec;
                count_next = 4'd0;
                if (tag_end)
                    phase_next = PH_PREV;
                else
                    phase_next = (data_byte == PKT_NALU) ? PH_COMPTIME : PH_SKIPTAG;
            end
            PH_COMPTIME:
            begin
                left_next = left_dec;
                if (tag_end)
                begin
                    phase_next = PH_PREV;
                    count_next = 4'd0;
                end
                else
                begin
                    count_next = cnt_inc;
                    if (cnt_inc >= COMPTIME_LEN)
                    begin
                        phase_next = PH_NALULEN;
                        count_next = 4'd0;
                        nalu_next  = 32'd0;
                    end
                end
            end
            PH_NALULEN:
            begin
                nalu_next  = nalu_shift;
                count_next = cnt_inc;
                left_next  = left_dec;
                if (tag_end)
                begin
                    phase_next = PH_PREV;
                    count_next = 4'd0;
                end
                else if (cnt_inc >= NALULEN_LEN)
                begin
                    count_next = 4'd0;
                    if (nalu_shift == 32'd0)
                        phase_next = PH_NALULEN;
                    else
                    begin
                        cut_next   = (nalu_shift > {8'd0, left_dec});
                        if (cut_next)
                            nalu_next = {8'd0, left_dec};
                        phase_next = PH_NALUDATA;
                    end
                end
            end
            PH_NALUDATA:
            begin
                nalu_next              = nalu_dec;
                emit                   = 1'b1;
                push_data.record_kind  = KIND_NALU_BYTE;
                push_data.payload_byte = data_byte;
                push_data.last_of_nalu = (nalu_dec == 32'd0);
                push_data.overrun      = cut_cur;
                left_next              = left_dec;
                if (tag_end)
                begin
                    phase_next = PH_PREV;
                    count_next = 4'd0;
                end
                else if (nalu_dec == 32'd0)
                begin
                    phase_next = PH_NALULEN;
                    count_next = 4'd0;
                    nalu_next  = 32'd0;
                    cut_next   = 1'b0;
                end
            end
            PH_SKIPTAG:
            begin
                left_next = left_dec;
                if (tag_end)
                begin
                    phase_next = PH_PREV;
                    count_next = 4'd0;
                end
            end
            default:
            begin
                phase_next = PH_PREV;
                count_next = 4'd0;
            end
        endcase
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 4'd0;
            pos_reg    <= 32'd0;
            offset_reg <= 32'd0;
            kind_reg   <= 5'd0;
            left_reg   <= 24'd0;
            time_reg   <= 32'd0;
            nalu_reg   <= 32'd0;
            cut_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            kind_reg   <= kind_next;
            left_reg   <= left_next;
            time_reg   <= time_next;
            nalu_reg   <= nalu_next;
            cut_reg    <= cut_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_reg <= 4'd7;
            emit_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AVC_CODEC_ID:     codec_reg <= cfg_data;
                CFG_EMIT_TAG_RECORDS: emit_reg  <= cfg_data[0];
                default:              codec_reg <= codec_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/flvd_queue.sv
`timescale 1ns / 1ps

module flvd_queue import flvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output result_t pop_data,
    output logic    full,
    output logic    empty
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hw/rtl/flvd_back.sv
`timescale 1ns / 1ps

module flvd_back import flvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  result_t q_data,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop        = !q_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // load the next beat whenever the output slot frees
    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_data;
    end

endmodule

>>> dv/tb_flv_avc_nalu_demux.sv
`timescale 1ns / 1ps

module tb_flv_avc_nalu_demux;
    import flvd_pkg::*;

    localparam logic [4:0] TAG_AUDIO   = 5'd8;
    localparam logic [4:0] TAG_SCRIPT  = 5'd18;
    localparam logic [7:0] PKT_SEQ_HDR = 8'd0;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_BYTES   = 260;

    class demux_scoreboard;
        logic [3:0]  codec_sel;
        logic        records_on;
        phase_t      stage;
        logic [3:0]  nbytes;
        logic [31:0] fpos;
        logic [31:0] body_start;
        logic [4:0]  cur_type;
        logic [23:0] tag_remain;
        logic [31:0] cur_stamp;
        logic [31:0] nalu_remain;
        logic        nalu_trunc;
        result_t     awaited[$];
        int          errors;

        function new();
            codec_sel = 4'd7;
            records_on = 1'b1;
            errors = 0;
            restart();
        endfunction

        function void restart();
            stage = PH_HEADER;
            nbytes = '0;
            fpos = '0;
            body_start = '0;
            cur_type = '0;
            tag_remain = '0;
            cur_stamp = '0;
            nalu_remain = '0;
            nalu_trunc = 1'b0;
        endfunction

        function void set_reg(logic idx, logic [3:0] value);
            if (idx == CFG_AVC_CODEC_ID)
                codec_sel = value;
            else
                records_on = value[0];
        endfunction

        function void enter(phase_t p);
            stage = p;
            nbytes = '0;
        endfunction

        function bit tag_byte_done();
            tag_remain = tag_remain - 24'd1;
            if (tag_remain == 24'd0)
            begin
                enter(PH_PREV);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic sof);
            result_t r;
            logic    last;
            bit      ended;
            if (sof)
                restart();
            fpos = fpos + 32'd1;
            case (stage)
                PH_HEADER:
                begin
                    if (nbytes >= HDR_OFFSET_POS)
                        body_start = {body_start[23:0], b};
                    nbytes = nbytes + 4'd1;
                    if (nbytes >= HDR_LEN)
                    begin
                        if (body_start <= MIN_BODY_OFFSET)
                            enter(PH_PREV);
                        else
                            enter(PH_SEEK);
                    end
                end
                PH_SEEK:
                begin
                    if (fpos >= body_start)
                        enter(PH_PREV);
                end
                PH_PREV:
                begin
                    nbytes = nbytes + 4'd1;
                    if (nbytes >= PREV_LEN)
                        enter(PH_TAGHDR);
                end
                PH_TAGHDR:
                begin
                    if (nbytes == 4'd0)
                    begin
                        cur_type = b[4:0];
                        tag_remain = '0;
                        cur_stamp = '0;
                    end
                    else if (nbytes <= SIZE_LAST_POS)
                        tag_remain = {tag_remain[15:0], b};
                    else if (nbytes <= TIME_LAST_POS)
                        cur_stamp = {8'h00, cur_stamp[15:0], b};
                    else if (nbytes == TIME_EXT_POS)
                        cur_stamp[31:24] = b;
                    nbytes = nbytes + 4'd1;
                    if (nbytes >= TAGHDR_LEN)
                    begin
                        if (records_on)
                        begin
                            r = '0;
                            r.record_kind = KIND_TAG_RECORD;
                            r.tag_kind = cur_type;
                            r.tag_size = tag_remain;
                            r.tag_time = cur_stamp;
                            awaited.push_back(r);
                        end
                        if (tag_remain == 24'd0)
                            enter(PH_PREV);
                        else if (cur_type == TAG_VIDEO)
                            enter(PH_VINFO);
                        else
                            enter(PH_SKIPTAG);
                    end
                end
                PH_VINFO:
                begin
                    if (!tag_byte_done())
                    begin
                        if (b[3:0] == codec_sel)
                            enter(PH_PKTTYPE);
                        else
                            enter(PH_SKIPTAG);
                    end
                end
                PH_PKTTYPE:
                begin
                    if (!tag_byte_done())
                    begin
                        if (b == PKT_NALU)
                            enter(PH_COMPTIME);
                        else
                            enter(PH_SKIPTAG);
                    end
                end
                PH_COMPTIME:
                begin
                    if (!tag_byte_done())
                    begin
                        nbytes = nbytes + 4'd1;
                        if (nbytes >= COMPTIME_LEN)
                        begin
                            enter(PH_NALULEN);
                            nalu_remain = '0;
                        end
                    end
                end
                PH_NALULEN:
                begin
                    nalu_remain = {nalu_remain[23:0], b};
                    nbytes = nbytes + 4'd1;
                    if (!tag_byte_done() && nbytes >= NALULEN_LEN)
                    begin
                        if (nalu_remain == 32'd0)
                            enter(PH_NALULEN);
                        else
                        begin
                            nalu_trunc = nalu_remain > {8'h00, tag_remain};
                            if (nalu_trunc)
                                nalu_remain = {8'h00, tag_remain};
                            enter(PH_NALUDATA);
                        end
                    end
                end
                PH_NALUDATA:
                begin
                    nalu_remain = nalu_remain - 32'd1;
                    last = (nalu_remain == 32'd0);
                    r = '0;
                    r.record_kind = KIND_NALU_BYTE;
                    r.payload_byte = b;
                    r.last_of_nalu = last;
                    r.overrun = nalu_trunc;
                    awaited.push_back(r);
                    ended = tag_byte_done();
                    if (!ended && last)
                    begin
                        enter(PH_NALULEN);
                        nalu_remain = '0;
                        nalu_trunc = 1'b0;
                    end
                end
                PH_SKIPTAG:
                begin
                    void'(tag_byte_done());
                end
                default:
                begin
                    enter(PH_PREV);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected beat kind=%0d byte=%02h", got.record_kind,
                                 got.payload_byte));
                return;
            end
            want = awaited.pop_front();
            cmp("record_kind", got.record_kind, want.record_kind);
            cmp("payload_byte", got.payload_byte, want.payload_byte);
            cmp("last_of_nalu", got.last_of_nalu, want.last_of_nalu);
            cmp("tag_kind", got.tag_kind, want.tag_kind);
            cmp("tag_size", got.tag_size, want.tag_size);
            cmp("tag_time", got.tag_time, want.tag_time);
            cmp("overrun", got.overrun, want.overrun);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        out_valid;
    logic        out_ready;
    logic        record_kind;
    logic [7:0]  payload_byte;
    logic        last_of_nalu;
    logic [4:0]  tag_kind;
    logic [23:0] tag_size;
    logic [31:0] tag_time;
    logic        overrun;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    demux_scoreboard sb;
    logic [7:0]      fbuf[$];
    int              bytes_sent;
    bit              steady;
    bit              hold_req;
    int              hold_left;

    flv_avc_nalu_demux dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_kind   (record_kind),
        .payload_byte  (payload_byte),
        .last_of_nalu  (last_of_nalu),
        .tag_kind      (tag_kind),
        .tag_size      (tag_size),
        .tag_time      (tag_time),
        .overrun       (overrun),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void put_be(ref logic [7:0] q[$], input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            q.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void put_rand(ref logic [7:0] q[$], input int n);
        repeat (n) q.push_back(8'($urandom));
    endfunction

    function automatic void add_tag(logic [3:0] codec);
        logic [7:0]  tb[$];
        logic [4:0]  ttype;
        logic [31:0] stamp;
        int          sel;
        int          nalus;
        int          len;
        sel = $urandom_range(99);
        ttype = TAG_VIDEO;
        if (sel < 70)
        begin
            tb.push_back({4'($urandom), codec});
            tb.push_back(PKT_NALU);
            put_rand(tb, 3);
            nalus = $urandom_range(1, 3);
            for (int k = 0; k < nalus; k++)
            begin
                len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24);
                if (k == nalus - 1 && $urandom_range(4) == 0)
                    put_be(tb, ($urandom_range(3) == 0) ? $urandom : len + $urandom_range(1, 8),
                           4);
                else
                    put_be(tb, len, 4);
                put_rand(tb, len);
            end
            // cut the tag short so it ends inside some field
            if (sel >= 60)
                repeat ($urandom_range(1, tb.size())) void'(tb.pop_back());
        end
        else if (sel < 76)
        begin
            tb.push_back({4'($urandom), codec ^ 4'($urandom_range(1, 15))});
            put_rand(tb, $urandom_range(0, 16));
        end
        else if (sel < 82)
        begin
            tb.push_back({4'($urandom), codec});
            tb.push_back(($urandom_range(1) == 0) ? PKT_SEQ_HDR : 8'($urandom_range(2, 255)));
            put_rand(tb, $urandom_range(0, 16));
        end
        else if (sel < 94)
        begin
            case ($urandom_range(2))
                0:       ttype = TAG_AUDIO;
                1:       ttype = TAG_SCRIPT;
                default: ttype = 5'($urandom);
            endcase
            put_rand(tb, $urandom_range(0, 24));
        end
        stamp = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 5000);
        put_rand(fbuf, 4);
        fbuf.push_back({3'($urandom), ttype});
        put_be(fbuf, tb.size(), 3);
        put_be(fbuf, stamp[23:0], 3);
        fbuf.push_back(stamp[31:24]);
        put_rand(fbuf, 3);
        fbuf = {fbuf, tb};
    endfunction

    function automatic bit build_file(logic [3:0] codec);
        logic [31:0] offset;
        int          pick;
        fbuf = {};
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            put_rand(fbuf, $urandom_range(8, 60));
            return 1'b1;
        end
        if (pick < 20)
            put_rand(fbuf, 5);
        else
            fbuf = {fbuf, 8'h46, 8'h4C, 8'h56, 8'h01, 8'h05};
        pick = $urandom_range(99);
        if (pick < 70)
            offset = MIN_BODY_OFFSET;
        else if (pick < 85)
            offset = $urandom_range(0, 8);
        else
            offset = $urandom_range(10, 40);
        put_be(fbuf, offset, 4);
        if (offset > MIN_BODY_OFFSET)
            put_rand(fbuf, offset - MIN_BODY_OFFSET);
        repeat ($urandom_range(1, 5)) add_tag(codec);
        // leave a partial or oversized tag behind for the next file to cut off
        if ($urandom_range(4) == 0)
            put_rand(fbuf, $urandom_range(1, 40));
        return 1'b0;
    endfunction

    task send_byte(logic [7:0] b, logic sof);
        if (!steady)
        begin
            while ($urandom_range(99) < 33)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        data_byte <= b;
        start_of_file <= sof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, sof);
        bytes_sent++;
    endtask

    task send_file(bit noisy);
        bit lead_sof;
        lead_sof = ($urandom_range(19) != 0);
        for (int i = 0; i < fbuf.size(); i++)
            send_byte(fbuf[i], (i == 0) ? lead_sof : (noisy && $urandom_range(31) == 0));
    endtask

    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task program_config(logic [3:0] codec, logic emit);
        cfg_we <= 1'b1;
        cfg_index <= CFG_AVC_CODEC_ID;
        cfg_data <= codec;
        @(posedge clk);
        sb.set_reg(CFG_AVC_CODEC_ID, codec);
        cfg_index <= CFG_EMIT_TAG_RECORDS;
        cfg_data <= {3'b000, emit};
        @(posedge clk);
        sb.set_reg(CFG_EMIT_TAG_RECORDS, {3'b000, emit});
        cfg_we <= 1'b0;
    endtask

    initial
    begin : receiver
        result_t got;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.record_kind = record_kind;
                got.payload_byte = payload_byte;
                got.last_of_nalu = last_of_nalu;
                got.tag_kind = tag_kind;
                got.tag_size = tag_size;
                got.tag_time = tag_time;
                got.overrun = overrun;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : main
        logic [3:0] codec_plan[6];
        logic       emit_plan[6];
        int         target;
        bit         noisy;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        start_of_file = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_AVC_CODEC_ID;
        cfg_data = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        bytes_sent = 0;
        sb = new();
        codec_plan = '{4'd7, 4'd0, 4'd15, 4'($urandom), 4'($urandom), 4'd3};
        emit_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            program_config(codec_plan[p], emit_plan[p]);
            steady = (p == 2);
            if (p == 1 || p == 4)
                hold_req = 1'b1;
            if (p == 0)
            begin
                // offset below the header size, then a header with every field at its top
                fbuf = {};
                repeat (5) fbuf.push_back(8'hFF);
                put_be(fbuf, 0, 4);
                put_be(fbuf, 0, 4);
                repeat (8) fbuf.push_back(8'hFF);
                put_be(fbuf, 0, 3);
                for (int i = 0; i < fbuf.size(); i++)
                    send_byte(fbuf[i], i == 0);
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                noisy = build_file(codec_plan[p]);
                send_file(noisy);
                if ($urandom_range(9) == 0)
                    drain();
            end
        end

        steady = 1'b0;
        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
